>>> rtl/core/l3d_pkg.sv
// Shared constants, types and helpers for the 3D life generation engine.
package l3d_pkg;

    localparam int SIDE        = 16;
    localparam int COORD_W     = 4;
    localparam int SIZE_W      = 5;
    localparam int ROWS        = SIDE * SIDE;
    localparam int ROW_AW      = 2 * COORD_W;
    localparam int LOOKAHEAD   = SIDE + 1;
    localparam int WIN_DEPTH   = 2 * LOOKAHEAD + 1;
    localparam int WRITE_DELAY = LOOKAHEAD + 1;
    localparam int SWEEP_LAST  = ROWS + LOOKAHEAD;
    localparam int CNT_W       = 9;
    localparam int TAPS        = 9;
    localparam int CENTER_TAP  = 4;
    localparam int SUM_W       = 4;
    localparam int COUNT_W     = 5;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [COUNT_W-1:0] BIRTH_COUNT  = 5'd6;
    localparam logic [COUNT_W-1:0] SURVIVE_LOW  = 5'd5;
    localparam logic [COUNT_W-1:0] SURVIVE_HIGH = 5'd8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SIDE);

    typedef logic [SIDE-1:0]    row_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]  side_t;
    typedef logic [SUM_W-1:0]   psum_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TAPS-1:0]    col_t;

    typedef struct packed {
        coord_t y;
        coord_t z;
    } sweep_pos_t;

    function automatic side_t side_in_use(input side_t gs);
        return (gs > SIZE_W'(SIDE)) ? SIZE_W'(SIDE) : gs;
    endfunction

endpackage

>>> rtl/core/life3d_generation_engine_top.sv
// Top level: row memory, command sequencer and generation sweep.
//
// A 16x16x16 cube of one-bit cells, kept as 256 rows of 16 cells (row = y + 16*z).
// After reset a clearing pass zeroes all 256 rows; busy is high meanwhile.
// Read, write and unused commands are taken every cycle while busy is low; each item's
// result strobes on done in the cycle right after it is accepted. A step keeps busy high
// throughout: one row of the memory is read per cycle, rows stream through a shift line
// 17 rows ahead of the row being updated, a chain of 16 cells applies the rule and
// the new row is written back in place. Its done strobe follows in the next cycle.
// The receiver cannot stall: each result is on alive_out and out_of_range for
// exactly the one cycle in which done is high.
module life3d_generation_engine_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  l3d_pkg::side_t          cfg_data,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              command,
    input  l3d_pkg::coord_t         coord_x,
    input  l3d_pkg::coord_t         coord_y,
    input  l3d_pkg::coord_t         coord_z,
    input  logic                    alive_in,
    output logic                    done,
    output logic                    alive_out,
    output logic                    out_of_range
);
    import l3d_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_STEP  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    side_t              grid_size_reg;
    logic               done_reg, done_next;
    logic               oor_reg, oor_next;
    logic               rd_hit_reg, rd_hit_next;
    coord_t             xsel_reg;

    row_t               grid_mem [ROWS];
    row_t               rdata_reg;

    logic               mem_we;
    logic [ROW_AW-1:0]  waddr;
    logic [ROW_AW-1:0]  raddr;
    row_t               wmask;
    row_t               wdata;

    side_t              s_eff;
    logic               in_range;
    logic               accept;
    logic [CNT_W-1:0]   wrow_full;
    sweep_pos_t         pos;
    row_t               new_row;

    assign s_eff    = side_in_use(grid_size_reg);
    assign in_range = ({1'b0, coord_x} < s_eff) && ({1'b0, coord_y} < s_eff)
                   && ({1'b0, coord_z} < s_eff);
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;

    assign wrow_full = cnt_reg - CNT_W'(WRITE_DELAY);
    assign pos.y     = wrow_full[COORD_W-1:0];
    assign pos.z     = wrow_full[ROW_AW-1:COORD_W];

    l3d_window u_window (
        .clk     (clk),
        .row_in  (rdata_reg),
        .pos     (pos),
        .side    (s_eff),
        .new_row (new_row)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        oor_next    = 1'b0;
        rd_hit_next = 1'b0;
        mem_we      = 1'b0;
        waddr       = {coord_z, coord_y};
        wmask       = '0;
        wdata       = {SIDE{alive_in}};
        raddr       = {coord_z, coord_y};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                waddr  = cnt_reg[ROW_AW-1:0];
                wmask  = '1;
                wdata  = '0;
                if (cnt_reg == CNT_W'(ROWS-1))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_STEP:
            begin
                raddr = cnt_reg[ROW_AW-1:0];
                if (cnt_reg >= CNT_W'(WRITE_DELAY))
                begin
                    mem_we = 1'b1;
                    waddr  = wrow_full[ROW_AW-1:0];
                    wmask  = '1;
                    wdata  = new_row;
                end
                if (cnt_reg == CNT_W'(SWEEP_LAST))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                    done_next  = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_WRITE:
                        begin
                            done_next = 1'b1;
                            oor_next  = !in_range;
                            mem_we    = in_range;
                            wmask     = row_t'(1) << coord_x;
                        end
                        CMD_READ:
                        begin
                            done_next   = 1'b1;
                            oor_next    = !in_range;
                            rd_hit_next = in_range;
                        end
                        CMD_STEP:
                        begin
                            state_next = ST_STEP;
                            cnt_next   = '0;
                        end
                        CMD_NOP:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            grid_size_reg <= SIZE_RESET;
            done_reg      <= 1'b0;
            oor_reg       <= 1'b0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            oor_reg    <= oor_next;
            rd_hit_reg <= rd_hit_next;
            if (cfg_we)
            begin
                grid_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xsel_reg <= coord_x;
        end
    end

    // bit-enable row memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            for (int i = 0; i < SIDE; i++)
            begin
                if (wmask[i])
                begin
                    grid_mem[waddr][i] <= wdata[i];
                end
            end
        end
        rdata_reg <= grid_mem[raddr];
    end

    assign done         = done_reg;
    assign out_of_range = oor_reg;
    assign alive_out    = rd_hit_reg & rdata_reg[xsel_reg];

endmodule

>>> rtl/core/l3d_cell.sv
// One column cell: 3x3 plane sum, neighbor sum exchange and B6/S5678 rule.
module l3d_cell (
    input  l3d_pkg::col_t  col,
    input  logic           old_bit,
    input  logic           in_cube,
    input  l3d_pkg::psum_t left_sum,
    input  l3d_pkg::psum_t right_sum,
    output l3d_pkg::psum_t own_sum,
    output logic           new_bit
);
    import l3d_pkg::*;

    count_t total;
    logic   survive;
    logic   born;

    assign own_sum = SUM_W'($countones(col));

    assign total = COUNT_W'(left_sum) + COUNT_W'(own_sum) + COUNT_W'(right_sum)
                 - COUNT_W'(col[CENTER_TAP]);

    assign survive = (total >= SURVIVE_LOW) && (total <= SURVIVE_HIGH);
    assign born    = (total == BIRTH_COUNT);

    always_comb
    begin
        if (in_cube)
        begin
            new_bit = old_bit ? survive : born;
        end
        else
        begin
            new_bit = old_bit;
        end
    end

endmodule

>>> rtl/core/l3d_window.sv
// Row shift line over two planes plus three rows, tap masking and the chain of cells.
module l3d_window (
    input  logic                clk,
    input  l3d_pkg::row_t       row_in,
    input  l3d_pkg::sweep_pos_t pos,
    input  l3d_pkg::side_t      side,
    output l3d_pkg::row_t       new_row
);
    import l3d_pkg::*;

    row_t  sl_reg [1:WIN_DEPTH-1];
    row_t  win    [WIN_DEPTH];
    row_t  tap_row [TAPS];
    row_t  xmask;
    psum_t psum [SIDE];
    logic [2:0] ok_y;
    logic [2:0] ok_z;
    side_t yw;
    side_t zw;

    always_ff @(posedge clk)
    begin
        sl_reg[1] <= row_in;
        for (int k = 2; k < WIN_DEPTH; k++)
        begin
            sl_reg[k] <= sl_reg[k-1];
        end
    end

    always_comb
    begin
        win[0] = row_in;
        for (int k = 1; k < WIN_DEPTH; k++)
        begin
            win[k] = sl_reg[k];
        end
    end

    assign yw = {1'b0, pos.y};
    assign zw = {1'b0, pos.z};

    // neighbor row in the cube, no wrap at the faces
    assign ok_y[0] = (pos.y != '0) && (yw <= side);
    assign ok_y[1] = (yw < side);
    assign ok_y[2] = ((yw + SIZE_W'(1)) < side);
    assign ok_z[0] = (pos.z != '0) && (zw <= side);
    assign ok_z[1] = (zw < side);
    assign ok_z[2] = ((zw + SIZE_W'(1)) < side);

    always_comb
    begin
        for (int i = 0; i < SIDE; i++)
        begin
            xmask[i] = (SIZE_W'(i) < side);
        end
    end

    // tap (dy, dz) sits LOOKAHEAD - dy - SIDE*dz rows back
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tap_row[j*3+i] = win[LOOKAHEAD + 1 + SIDE - i - SIDE*j] & xmask
                               & {SIDE{ok_y[i] & ok_z[j]}};
            end
        end
    end

    for (genvar x = 0; x < SIDE; x++)
    begin : g_cell
        col_t  col;
        psum_t left_sum;
        psum_t right_sum;

        always_comb
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                col[t] = tap_row[t][x];
            end
        end

        if (x == 0)
        begin : g_left_edge
            assign left_sum = '0;
        end
        else
        begin : g_left
            assign left_sum = psum[x-1];
        end

        if (x == SIDE-1)
        begin : g_right_edge
            assign right_sum = '0;
        end
        else
        begin : g_right
            assign right_sum = psum[x+1];
        end

        l3d_cell u_cell (
            .col       (col),
            .old_bit   (win[LOOKAHEAD][x]),
            .in_cube   (xmask[x] & ok_y[1] & ok_z[1]),
            .left_sum  (left_sum),
            .right_sum (right_sum),
            .own_sum   (psum[x]),
            .new_bit   (new_row[x])
        );
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the 3D life generation engine: seeded patterns, steps and read-back.
`timescale 1ns / 1ps

module testbench;
    import l3d_pkg::*;

    localparam int GRID_MAX     = 16;
    localparam int LIFE_BORN    = 6;
    localparam int LIFE_KEEP_LO = 5;
    localparam int LIFE_KEEP_HI = 8;
    localparam int PHASE_ITEMS  = 55;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [1:0] cmd;
        coord_t     x;
        coord_t     y;
        coord_t     z;
        logic       alive;
    } cell_cmd_t;

    typedef struct packed {
        logic alive;
        logic oor;
    } cell_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    side_t      cfg_data = '0;
    logic       start = 1'b0;
    logic [1:0] command = CMD_NOP;
    coord_t     coord_x = '0;
    coord_t     coord_y = '0;
    coord_t     coord_z = '0;
    logic       alive_in = 1'b0;
    logic       busy;
    logic       done;
    logic       alive_out;
    logic       out_of_range;

    bit [GRID_MAX**3-1:0] cells = '0;
    side_t                grid_cfg = side_t'(GRID_MAX);
    cell_cmd_t            pending_cmds[$];
    cell_result_t         expected_results[$];
    int                   idle_pct = 0;
    int                   errors = 0;
    int                   stall_cycles = 0;
    int                   phase_sizes[12] = '{3, 0, 16, 1, 2, 31, 5, 17, 8, 4, 16, 0};

    life3d_generation_engine_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .alive_in     (alive_in),
        .done         (done),
        .alive_out    (alive_out),
        .out_of_range (out_of_range)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int cube_side();
        return (grid_cfg > GRID_MAX) ? GRID_MAX : int'(grid_cfg);
    endfunction

    function automatic int cell_addr(int x, int y, int z);
        return x + GRID_MAX * (y + GRID_MAX * z);
    endfunction

    // Counts are taken from the old generation for every cell before any update.
    function automatic void advance_cells();
        bit [GRID_MAX**3-1:0] prev;
        int s;
        int n;
        int nx;
        int ny;
        int nz;
        prev = cells;
        s = cube_side();
        for (int z = 0; z < s; z++)
            for (int y = 0; y < s; y++)
                for (int x = 0; x < s; x++)
                begin
                    n = 0;
                    for (int dz = -1; dz <= 1; dz++)
                        for (int dy = -1; dy <= 1; dy++)
                            for (int dx = -1; dx <= 1; dx++)
                            begin
                                nx = x + dx;
                                ny = y + dy;
                                nz = z + dz;
                                if ((dx != 0 || dy != 0 || dz != 0) &&
                                    nx >= 0 && ny >= 0 && nz >= 0 &&
                                    nx < s && ny < s && nz < s)
                                    n += prev[cell_addr(nx, ny, nz)];
                            end
                    if (prev[cell_addr(x, y, z)])
                        cells[cell_addr(x, y, z)] = (n >= LIFE_KEEP_LO && n <= LIFE_KEEP_HI);
                    else
                        cells[cell_addr(x, y, z)] = (n == LIFE_BORN);
                end
    endfunction

    function automatic cell_result_t apply_command(cell_cmd_t it);
        cell_result_t r;
        int s;
        r = '0;
        s = cube_side();
        case (it.cmd)
            CMD_WRITE, CMD_READ:
            begin
                if (it.x >= s || it.y >= s || it.z >= s)
                    r.oor = 1'b1;
                else if (it.cmd == CMD_WRITE)
                    cells[cell_addr(it.x, it.y, it.z)] = it.alive;
                else
                    r.alive = cells[cell_addr(it.x, it.y, it.z)];
            end
            CMD_STEP: advance_cells();
            default: ;
        endcase
        return r;
    endfunction

    always @(negedge clk)
    begin : driver
        if (rst_n && pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
        begin
            start    <= 1'b1;
            command  <= pending_cmds[0].cmd;
            coord_x  <= pending_cmds[0].x;
            coord_y  <= pending_cmds[0].y;
            coord_z  <= pending_cmds[0].z;
            alive_in <= pending_cmds[0].alive;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        cell_result_t want;
        cell_cmd_t    taken;
        bit           progress;
        if (rst_n)
        begin
            progress = 1'b0;
            if (done)
            begin
                progress = 1'b1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected: alive_out %0b out_of_range %0b",
                             $time, alive_out, out_of_range);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (alive_out !== want.alive)
                    begin
                        $display("%0t: alive_out expected %0b got %0b",
                                 $time, want.alive, alive_out);
                        errors++;
                    end
                    if (out_of_range !== want.oor)
                    begin
                        $display("%0t: out_of_range expected %0b got %0b",
                                 $time, want.oor, out_of_range);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                progress = 1'b1;
                taken = '{cmd: command, x: coord_x, y: coord_y, z: coord_z, alive: alive_in};
                expected_results.push_back(apply_command(taken));
                void'(pending_cmds.pop_front());
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_cmd(logic [1:0] c, int x, int y, int z, logic a);
        pending_cmds.push_back('{cmd: c, x: coord_t'(x), y: coord_t'(y), z: coord_t'(z),
                                 alive: a});
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_grid_size(int v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= side_t'(v);
        grid_cfg = side_t'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int near_box(int base, int dim, int s);
        int lo;
        int hi;
        lo = (base > 0) ? base - 1 : 0;
        hi = (base + dim < s) ? base + dim : s - 1;
        return $urandom_range(hi, lo);
    endfunction

    // Mostly seeded blocks followed by steps and read-back; the rest is noise.
    task automatic build_phase(int n_items);
        int s;
        int made;
        int dim;
        int bx;
        int by;
        int bz;
        int dens;
        int r;
        s = cube_side();
        made = 0;
        while (made < n_items)
        begin
            if (s > 0 && $urandom_range(99) < 60)
            begin
                dim = 1 + $urandom_range(((s < 4) ? s : 4) - 1);
                bx = $urandom_range(s - dim);
                by = $urandom_range(s - dim);
                bz = $urandom_range(s - dim);
                dens = $urandom_range(70, 20);
                for (int z = 0; z < dim; z++)
                    for (int y = 0; y < dim; y++)
                        for (int x = 0; x < dim; x++)
                            push_cmd(CMD_WRITE, bx + x, by + y, bz + z,
                                     $urandom_range(99) < dens);
                made += dim * dim * dim;
                repeat (1 + $urandom_range(1))
                begin
                    push_cmd(CMD_STEP, $urandom_range(15), $urandom_range(15),
                             $urandom_range(15), 1'($urandom_range(1)));
                    made++;
                end
                repeat (10)
                    push_cmd(CMD_READ, near_box(bx, dim, s), near_box(by, dim, s),
                             near_box(bz, dim, s), 1'($urandom_range(1)));
                made += 10;
            end
            else
            begin
                r = $urandom_range(99);
                push_cmd((r < 45) ? CMD_WRITE : (r < 85) ? CMD_READ : (r < 90) ? CMD_STEP
                         : CMD_NOP, $urandom_range(15), $urandom_range(15),
                         $urandom_range(15), 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);

        // corners, a birth site with six face neighbours, read-back, unused command
        push_cmd(CMD_WRITE, 0, 0, 0, 1'b1);
        push_cmd(CMD_WRITE, 15, 15, 15, 1'b1);
        push_cmd(CMD_READ, 0, 0, 0, 1'b0);
        push_cmd(CMD_READ, 15, 15, 15, 1'b0);
        push_cmd(CMD_READ, 7, 8, 9, 1'b1);
        push_cmd(CMD_WRITE, 4, 5, 5, 1'b1);
        push_cmd(CMD_WRITE, 6, 5, 5, 1'b1);
        push_cmd(CMD_WRITE, 5, 4, 5, 1'b1);
        push_cmd(CMD_WRITE, 5, 6, 5, 1'b1);
        push_cmd(CMD_WRITE, 5, 5, 4, 1'b1);
        push_cmd(CMD_WRITE, 5, 5, 6, 1'b1);
        push_cmd(CMD_NOP, 15, 15, 15, 1'b1);
        push_cmd(CMD_STEP, 0, 0, 0, 1'b0);
        push_cmd(CMD_READ, 5, 5, 5, 1'b0);
        push_cmd(CMD_READ, 4, 5, 5, 1'b0);
        push_cmd(CMD_READ, 0, 0, 0, 1'b0);
        push_cmd(CMD_WRITE, 15, 15, 15, 1'b0);
        push_cmd(CMD_READ, 15, 15, 15, 1'b1);
        drain();

        for (int i = 0; i < 12; i++)
        begin
            set_grid_size((i == 10) ? $urandom_range(16, 1) : phase_sizes[i]);
            idle_pct = (i % 3 == 0) ? 0 : (i % 3 == 1) ? 72 : 29;
            build_phase(PHASE_ITEMS);
            drain();
        end

        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
